>>> src/grd_pkg.sv
// ----------------------------------------------------------------------------
// grd_pkg: shared definitions for the ghost reflection detector
// Field widths, register reset values, event kind codes, configuration
// register indexes, marker record types and the back-end state encoding.
// ----------------------------------------------------------------------------
package grd_pkg;

  localparam int unsigned MaxMarkersDef = 64;

  localparam int unsigned IdentW = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned WinW   = 8;
  localparam int unsigned DistW  = 24;
  localparam int unsigned TotalW = 7;
  localparam int unsigned CapW   = 7;
  localparam int unsigned TolW   = 24;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CapW-1:0] CapReset = 7'd64;
  localparam logic [TolW-1:0] TolReset = 24'd80;

  localparam logic [KindW-1:0] KIND_REFLECT = 3'd1;
  localparam logic [KindW-1:0] KIND_GHOST   = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ID_CAPACITY     = 1'b0,
    CFG_GHOST_TOLERANCE = 1'b1
  } grd_cfg_e;

  typedef struct packed {
    logic [IdentW-1:0] ident;
    logic [WinW-1:0]   window;
    logic [DistW-1:0]  distance;
    logic              cand;
    logic              refl;
  } grd_entry_t;

  typedef struct packed {
    grd_entry_t entry;
    logic       last;
  } grd_marker_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_A_RD,
    ST_A_CHK,
    ST_B_RD,
    ST_B_CHK,
    ST_FINAL
  } grd_state_e;

endpackage

>>> src/grd_front.sv
// ----------------------------------------------------------------------------
// grd_front: marker intake and classification
// Accepts markers, tags them as search candidates and as reflections, and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module grd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [grd_pkg::IdentW-1:0]          in_ident_i,
  input  logic [grd_pkg::KindW-1:0]           in_kind_i,
  input  logic [grd_pkg::WinW-1:0]            in_window_i,
  input  logic [grd_pkg::DistW-1:0]           in_dist_i,
  input  logic                                in_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output grd_pkg::grd_marker_t                out_marker_o
);

  logic [1:0]           cnt_q, cnt_d;
  logic                 wp_q, wp_d;
  logic                 rp_q, rp_d;
  logic                 push, pop;
  grd_pkg::grd_marker_t slot_q [2];
  grd_pkg::grd_marker_t in_marker;

  always_comb begin
    in_marker.entry.ident    = in_ident_i;
    in_marker.entry.window   = in_window_i;
    in_marker.entry.distance = in_dist_i;
    in_marker.entry.refl     = (in_kind_i == grd_pkg::KIND_REFLECT);
    in_marker.entry.cand     = in_kind_i inside {grd_pkg::KIND_REFLECT, grd_pkg::KIND_GHOST};
    in_marker.last           = in_last_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign out_valid_o  = (cnt_q != 2'd0);
  assign out_marker_o = slot_q[rp_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    wp_d  = wp_q;
    rp_d  = rp_q;
    if (push) begin
      wp_d = ~wp_q;
    end
    if (pop) begin
      rp_d = ~rp_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wp_q  <= wp_d;
      rp_q  <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= in_marker;
    end
  end

endmodule

>>> src/grd_back.sv
// ----------------------------------------------------------------------------
// grd_back: marker store, pairwise ghost search and result register
// Writes markers into the store and, on the last marker of a set, scans each
// candidate against stored markers to its first match, sending ghost ids.
// ----------------------------------------------------------------------------
module grd_back #(
  parameter int unsigned MaxMarkers = grd_pkg::MaxMarkersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  grd_pkg::grd_marker_t          in_marker_i,
  input  logic [grd_pkg::CapW-1:0]      id_capacity_i,
  input  logic [grd_pkg::TolW-1:0]      ghost_tolerance_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [grd_pkg::IdentW-1:0]    out_ident_o,
  output logic                          out_has_ident_o,
  output logic [grd_pkg::TotalW-1:0]    out_total_o,
  output logic                          out_final_o
);

  localparam int unsigned CntW = $clog2(MaxMarkers + 1);
  localparam int unsigned IdxW = $clog2(MaxMarkers);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxMarkers);

  grd_pkg::grd_state_e          state_q, state_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [CntW-1:0]              a_q, a_d;
  logic [CntW-1:0]              b_q, b_d;
  logic [grd_pkg::TotalW-1:0]   total_q, total_d;
  logic                         pend_valid_q, pend_valid_d;
  logic [grd_pkg::IdentW-1:0]   pend_ident_q, pend_ident_d;

  logic                         ov_q, ov_d;
  logic [grd_pkg::IdentW-1:0]   oid_q, oid_d;
  logic                         ohas_q, ohas_d;
  logic [grd_pkg::TotalW-1:0]   otot_q, otot_d;
  logic                         ofin_q, ofin_d;

  grd_pkg::grd_entry_t          store_mem [MaxMarkers];
  grd_pkg::grd_entry_t          rd_a_q, rd_b_q;
  logic                         mem_we, rd_a_en, rd_b_en;

  logic [grd_pkg::DistW:0]      dist_a, twice_b, delta;
  logic                         close, match, emit_ok, slot_free;

  always_comb begin
    dist_a  = {1'b0, rd_a_q.distance};
    twice_b = {rd_b_q.distance, 1'b0};
    delta   = (dist_a >= twice_b) ? (dist_a - twice_b) : (twice_b - dist_a);
    close   = (delta < {1'b0, ghost_tolerance_i});
    match   = (b_q != a_q) && (rd_b_q.window == rd_a_q.window) && rd_b_q.refl && close;
    emit_ok = (total_q < id_capacity_i);
  end

  assign slot_free = !ov_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    a_d          = a_q;
    b_d          = b_q;
    total_d      = total_q;
    pend_valid_d = pend_valid_q;
    pend_ident_d = pend_ident_q;
    ov_d         = ov_q && !out_ready_i;
    oid_d        = oid_q;
    ohas_d       = ohas_q;
    otot_d       = otot_q;
    ofin_d       = ofin_q;
    in_ready_o   = 1'b0;
    mem_we       = 1'b0;
    rd_a_en      = 1'b0;
    rd_b_en      = 1'b0;
    case (state_q)
      grd_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (count_q < CntMax) begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (in_marker_i.last) begin
            a_d          = '0;
            total_d      = '0;
            pend_valid_d = 1'b0;
            state_d      = grd_pkg::ST_A_RD;
          end
        end
      end
      grd_pkg::ST_A_RD: begin
        if (a_q == count_q) begin
          state_d = grd_pkg::ST_FINAL;
        end else begin
          rd_a_en = 1'b1;
          state_d = grd_pkg::ST_A_CHK;
        end
      end
      grd_pkg::ST_A_CHK: begin
        if (rd_a_q.cand) begin
          b_d     = '0;
          state_d = grd_pkg::ST_B_RD;
        end else begin
          a_d     = a_q + 1'b1;
          state_d = grd_pkg::ST_A_RD;
        end
      end
      grd_pkg::ST_B_RD: begin
        if (b_q == count_q) begin
          a_d     = a_q + 1'b1;
          state_d = grd_pkg::ST_A_RD;
        end else begin
          rd_b_en = 1'b1;
          state_d = grd_pkg::ST_B_CHK;
        end
      end
      grd_pkg::ST_B_CHK: begin
        if (!match) begin
          b_d     = b_q + 1'b1;
          state_d = grd_pkg::ST_B_RD;
        end else if (emit_ok && pend_valid_q) begin
          if (slot_free) begin
            ov_d         = 1'b1;
            oid_d        = pend_ident_q;
            ohas_d       = 1'b1;
            otot_d       = '0;
            ofin_d       = 1'b0;
            pend_ident_d = rd_a_q.ident;
            total_d      = total_q + 1'b1;
            a_d          = a_q + 1'b1;
            state_d      = grd_pkg::ST_A_RD;
          end
        end else begin
          if (emit_ok) begin
            pend_valid_d = 1'b1;
            pend_ident_d = rd_a_q.ident;
          end
          total_d = total_q + 1'b1;
          a_d     = a_q + 1'b1;
          state_d = grd_pkg::ST_A_RD;
        end
      end
      grd_pkg::ST_FINAL: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oid_d   = pend_valid_q ? pend_ident_q : '0;
          ohas_d  = pend_valid_q;
          otot_d  = total_q;
          ofin_d  = 1'b1;
          count_d = '0;
          state_d = grd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = grd_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= grd_pkg::ST_LOAD;
      count_q      <= '0;
      a_q          <= '0;
      b_q          <= '0;
      total_q      <= '0;
      pend_valid_q <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      a_q          <= a_d;
      b_q          <= b_d;
      total_q      <= total_d;
      pend_valid_q <= pend_valid_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_ident_q <= pend_ident_d;
    oid_q        <= oid_d;
    ohas_q       <= ohas_d;
    otot_q       <= otot_d;
    ofin_q       <= ofin_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[count_q[IdxW-1:0]] <= in_marker_i.entry;
    end
    if (rd_a_en) begin
      rd_a_q <= store_mem[a_q[IdxW-1:0]];
    end
    if (rd_b_en) begin
      rd_b_q <= store_mem[b_q[IdxW-1:0]];
    end
  end

  assign out_valid_o     = ov_q;
  assign out_ident_o     = oid_q;
  assign out_has_ident_o = ohas_q;
  assign out_total_o     = otot_q;
  assign out_final_o     = ofin_q;

endmodule

>>> src/ghost_reflection_detect.sv
// A marker passes through the front queue before it is written into the store.
// Throughput: one marker per cycle while a set is loading.
// Search on the last marker: each stored marker is read in turn and each candidate is
// compared with them by the single pairwise compare unit; a final result follows.
// During the search the front queue takes at most two further markers. Reset clears all
// control state and the configuration registers (id capacity 64, tolerance 80).
// ----------------------------------------------------------------------------
// ghost_reflection_detect: ghost reflection detector for fibre trace markers
// Collects markers per set and reports, up to the id capacity, each reflection or ghost
// marker within tolerance of twice the distance of another reflection in its window.
// ----------------------------------------------------------------------------
module ghost_reflection_detect #(
  parameter int unsigned MaxMarkers = grd_pkg::MaxMarkersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] marker_ident, [39:32] window_ident, [63:40] distance
  input  logic [63:0]                   s_axis_tdata,
  // [2:0] event_kind
  input  logic [2:0]                    s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] ghost_ident, [38:32] ghost_total, [39] zero
  output logic [39:0]                   m_axis_tdata,
  // [0] has_ident
  output logic [0:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [grd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [grd_pkg::TolW-1:0]      cfg_data_i
);

  logic [grd_pkg::CapW-1:0]   cap_q, cap_d;
  logic [grd_pkg::TolW-1:0]   tol_q, tol_d;
  logic                       q_valid, q_ready;
  grd_pkg::grd_marker_t       q_marker;
  logic [grd_pkg::IdentW-1:0] res_ident;
  logic                       res_has;
  logic [grd_pkg::TotalW-1:0] res_total;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cap_d = cap_q;
    tol_d = tol_q;
    if (cfg_valid_i) begin
      case (grd_pkg::grd_cfg_e'(cfg_index_i))
        grd_pkg::CFG_ID_CAPACITY:     cap_d = cfg_data_i[grd_pkg::CapW-1:0];
        grd_pkg::CFG_GHOST_TOLERANCE: tol_d = cfg_data_i;
        default: begin
          cap_d = cap_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= grd_pkg::CapReset;
      tol_q <= grd_pkg::TolReset;
    end else begin
      cap_q <= cap_d;
      tol_q <= tol_d;
    end
  end

  grd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_ident_i   (s_axis_tdata[31:0]),
    .in_kind_i    (s_axis_tuser),
    .in_window_i  (s_axis_tdata[39:32]),
    .in_dist_i    (s_axis_tdata[63:40]),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (q_valid),
    .out_ready_i  (q_ready),
    .out_marker_o (q_marker)
  );

  grd_back #(
    .MaxMarkers (MaxMarkers)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (q_valid),
    .in_ready_o        (q_ready),
    .in_marker_i       (q_marker),
    .id_capacity_i     (cap_q),
    .ghost_tolerance_i (tol_q),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_ident_o       (res_ident),
    .out_has_ident_o   (res_has),
    .out_total_o       (res_total),
    .out_final_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, res_total, res_ident};
  assign m_axis_tuser = res_has;

endmodule

>>> src/grd_checker.sv
// ----------------------------------------------------------------------------
// grd_checker: port-level checks for the ghost reflection detector
// Watches the result channel for stalls and for the layout of empty, final
// and intermediate results.
// ----------------------------------------------------------------------------
module grd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("result without an id is not the final one");

  a_empty_ident_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("result without an id carries a nonzero id");

  a_total_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[38:32] == 7'd0)
    else $error("intermediate result carries a nonzero total");

endmodule

bind ghost_reflection_detect grd_checker u_grd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
